// File: src/vwfm_pkg.sv
// shared types and constants for the voltage window fault monitor
`timescale 1ns / 1ps

package vwfm_pkg;

    localparam int unsigned LEVEL_W  = 16;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned SETTLE_W = 6;
    localparam int unsigned CFG_W    = 16;

    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [SETTLE_W-1:0] settle_t;
    typedef logic [CFG_W-1:0]    cfg_data_t;
    typedef logic [2:0]          cfg_idx_t;

    typedef enum logic [1:0] {
        ZONE_UNDER  = 2'd0,
        ZONE_NORMAL = 2'd1,
        ZONE_OVER   = 2'd2
    } zone_t;

    localparam cfg_idx_t CFG_FAULT_LOW  = 3'd0;
    localparam cfg_idx_t CFG_FAULT_HIGH = 3'd1;
    localparam cfg_idx_t CFG_WARN_LOW   = 3'd2;
    localparam cfg_idx_t CFG_WARN_HIGH  = 3'd3;
    localparam cfg_idx_t CFG_DEBOUNCE   = 3'd4;

    localparam settle_t SETTLE_MAX     = 6'd50;
    localparam count_t  DEBOUNCE_RESET = 8'd30;
    localparam level_t  LEVEL_MIN      = 16'h0000;
    localparam level_t  LEVEL_MAX      = 16'hFFFF;

endpackage

// File: src/voltage_window_fault_monitor_core.sv
// debounced voltage window monitor with hysteresis and sticky fault status
// an accepted sample beat is held in the input register, then its result beat in the result register
// throughput: one sample per cycle while out_stall is low, set by the single zone update stage
// input and output registers are parted so a sample is taken while a result waits
// reset: zone normal, counters and latches clear, limits at their default values
`timescale 1ns / 1ps

module voltage_window_fault_monitor_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  vwfm_pkg::level_t     sample,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           mode,
    output logic                 under_fault,
    output logic                 over_fault,
    input  logic                 cfg_we,
    input  vwfm_pkg::cfg_idx_t   cfg_index,
    input  vwfm_pkg::cfg_data_t  cfg_data
);

    import vwfm_pkg::*;

    level_t  fault_low_reg;
    level_t  fault_high_reg;
    level_t  warn_low_reg;
    level_t  warn_high_reg;
    count_t  debounce_reg;

    logic    s1_valid_reg;
    level_t  s1_sample_reg;

    zone_t   zone_reg;
    zone_t   zone_next;
    logic    under_latched_reg;
    logic    under_latched_next;
    logic    over_latched_reg;
    logic    over_latched_next;
    count_t  under_count_reg;
    count_t  under_count_next;
    count_t  over_count_reg;
    count_t  over_count_next;
    settle_t settle_count_reg;
    settle_t settle_count_next;
    logic    under_status_reg;
    logic    under_status_next;
    logic    over_status_reg;
    logic    over_status_next;

    logic    out_valid_reg;
    logic [1:0] mode_reg;
    logic    under_fault_reg;
    logic    over_fault_reg;

    logic    s2_load;
    logic    s1_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_low_reg  <= LEVEL_MIN;
            fault_high_reg <= LEVEL_MAX;
            warn_low_reg   <= LEVEL_MIN;
            warn_high_reg  <= LEVEL_MAX;
            debounce_reg   <= DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FAULT_LOW:  fault_low_reg  <= cfg_data;
                CFG_FAULT_HIGH: fault_high_reg <= cfg_data;
                CFG_WARN_LOW:   warn_low_reg   <= cfg_data;
                CFG_WARN_HIGH:  warn_high_reg  <= cfg_data;
                CFG_DEBOUNCE:   debounce_reg   <= cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // beat flow
    assign s2_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_stall = !s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_sample_reg <= sample;
        end
    end

    // zone and counter update
    always_comb
    begin
        zone_next          = zone_reg;
        under_latched_next = under_latched_reg;
        over_latched_next  = over_latched_reg;
        under_count_next   = under_count_reg;
        over_count_next    = over_count_reg;
        settle_count_next  = settle_count_reg;
        case (zone_reg)
            ZONE_UNDER:
            begin
                if (s1_sample_reg >= fault_low_reg && s1_sample_reg < warn_low_reg)
                begin
                    if (!under_latched_reg)
                    begin
                        zone_next = ZONE_NORMAL;
                    end
                end
                else if (s1_sample_reg >= warn_low_reg && s1_sample_reg <= fault_high_reg)
                begin
                    zone_next = ZONE_NORMAL;
                end
                else if (s1_sample_reg > fault_high_reg)
                begin
                    zone_next = ZONE_OVER;
                end
                else if (under_count_reg < debounce_reg)
                begin
                    under_count_next  = under_count_reg + count_t'(1);
                    over_latched_next = 1'b0;
                    over_count_next   = '0;
                end
                else
                begin
                    under_latched_next = 1'b1;
                end
            end
            ZONE_NORMAL:
            begin
                if (s1_sample_reg < fault_low_reg)
                begin
                    zone_next         = ZONE_UNDER;
                    settle_count_next = '0;
                end
                else if (s1_sample_reg > fault_high_reg)
                begin
                    zone_next         = ZONE_OVER;
                    settle_count_next = '0;
                end
                else if (settle_count_reg < SETTLE_MAX)
                begin
                    settle_count_next  = settle_count_reg + settle_t'(1);
                    under_latched_next = 1'b0;
                    over_latched_next  = 1'b0;
                    under_count_next   = '0;
                    over_count_next    = '0;
                end
            end
            ZONE_OVER:
            begin
                if (s1_sample_reg < fault_low_reg)
                begin
                    zone_next = ZONE_UNDER;
                end
                else if (s1_sample_reg <= warn_high_reg)
                begin
                    zone_next = ZONE_NORMAL;
                end
                else if (s1_sample_reg <= fault_high_reg)
                begin
                    if (!over_latched_reg)
                    begin
                        zone_next = ZONE_NORMAL;
                    end
                end
                else if (over_count_reg < debounce_reg)
                begin
                    over_count_next    = over_count_reg + count_t'(1);
                    under_latched_next = 1'b0;
                    under_count_next   = '0;
                end
                else
                begin
                    over_latched_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // sticky status follows the zone held before the sample
    always_comb
    begin
        under_status_next = under_status_reg;
        over_status_next  = over_status_reg;
        case (zone_reg)
            ZONE_UNDER:
            begin
                if (under_latched_next)
                begin
                    under_status_next = 1'b1;
                    over_status_next  = 1'b0;
                end
            end
            ZONE_NORMAL:
            begin
                under_status_next = 1'b0;
                over_status_next  = 1'b0;
            end
            ZONE_OVER:
            begin
                if (over_latched_next)
                begin
                    over_status_next  = 1'b1;
                    under_status_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg          <= ZONE_NORMAL;
            under_latched_reg <= 1'b0;
            over_latched_reg  <= 1'b0;
            under_count_reg   <= '0;
            over_count_reg    <= '0;
            settle_count_reg  <= '0;
            under_status_reg  <= 1'b0;
            over_status_reg   <= 1'b0;
        end
        else if (s2_load)
        begin
            zone_reg          <= zone_next;
            under_latched_reg <= under_latched_next;
            over_latched_reg  <= over_latched_next;
            under_count_reg   <= under_count_next;
            over_count_reg    <= over_count_next;
            settle_count_reg  <= settle_count_next;
            under_status_reg  <= under_status_next;
            over_status_reg   <= over_status_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            mode_reg        <= zone_next;
            under_fault_reg <= under_status_next;
            over_fault_reg  <= over_status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mode        = mode_reg;
    assign under_fault = under_fault_reg;
    assign over_fault  = over_fault_reg;

endmodule
